// File: design/ehcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elapsed hours to calendar date: shared package
// Widths, register indexes, queue word type, state types and the calendar
// helper functions used by the front, the queue, the back and the top level.
// ----------------------------------------------------------------------------
package ehcd_pkg;

   // Field widths.
   localparam int HOURS_W     = 24;
   localparam int DAYS_W      = 24;
   localparam int HOUR_W      = 10;
   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 16;
   localparam int BASE_YEAR_W = 14;
   localparam int YMOD_W      = 9;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 14;

   // Remaining day count in the back; a day past the end of its month can add
   // a couple of days on the first step, so one bit of headroom is kept.
   localparam int DAYS_ACC_W = 25;
   localparam logic [DAYS_ACC_W-1:0] DAYS_PER_400_YEARS = 25'd146097;

   localparam int QUEUE_DEPTH_DEF = 2;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HOURS_PER_DAY = 2'd0,
      REG_BASE_DAY      = 2'd1,
      REG_BASE_MONTH    = 2'd2,
      REG_BASE_YEAR     = 2'd3
   } csr_index_type;

   // One word between the front and the back.
   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic [HOUR_W-1:0] hour;
   } queue_item_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_RUN,
      BACK_DONE
   } back_state_type;

   // Year modulo 400 by six conditional subtractions (binary long division).
   function automatic logic [YMOD_W-1:0] year_mod_400(input logic [BASE_YEAR_W-1:0] year);
      logic [BASE_YEAR_W-1:0] rem;
      rem = year;
      if (rem >= 14'd12800) rem = rem - 14'd12800;
      if (rem >= 14'd6400)  rem = rem - 14'd6400;
      if (rem >= 14'd3200)  rem = rem - 14'd3200;
      if (rem >= 14'd1600)  rem = rem - 14'd1600;
      if (rem >= 14'd800)   rem = rem - 14'd800;
      if (rem >= 14'd400)   rem = rem - 14'd400;
      return rem[YMOD_W-1:0];
   endfunction

   // Gregorian leap year from the year's position in the 400-year cycle.
   function automatic logic leap_year(input logic [YMOD_W-1:0] ymod);
      return (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200) &&
             (ymod != 9'd300);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] dim;
      case (month)
         4'd1:    dim = 5'd31;
         4'd2:    dim = leap ? 5'd29 : 5'd28;
         4'd3:    dim = 5'd31;
         4'd4:    dim = 5'd30;
         4'd5:    dim = 5'd31;
         4'd6:    dim = 5'd30;
         4'd7:    dim = 5'd31;
         4'd8:    dim = 5'd31;
         4'd9:    dim = 5'd30;
         4'd10:   dim = 5'd31;
         4'd11:   dim = 5'd30;
         4'd12:   dim = 5'd31;
         default: dim = 5'd0;
      endcase
      return dim;
   endfunction

   function automatic logic [8:0] year_length(input logic leap);
      return leap ? 9'd366 : 9'd365;
   endfunction

endpackage

// File: design/elapsed_hours_to_calendar_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elapsed hours to calendar date: top level
// Each word carries a count of elapsed hours; the result word gives the
// local day, month, year and hour after adding that time to a base date.
// ----------------------------------------------------------------------------
// Timing: the front divides by the day length with a one-bit-per-cycle
// divider, one word at a time. A two-word queue lets it run ahead of the
// back, which steps the date one move per cycle: a 400-year cycle, a whole
// year from the first of January or a month, then the final days, after a
// load and before a hand-off. The divider sets the sustained rate for spans
// of a year or two, the date stepper for longer ones. Registers are to be
// written through the csr_ port while no word is in flight; the block itself
// does not enforce this, and csr_ready is always high.
// ----------------------------------------------------------------------------
module elapsed_hours_to_calendar_date
   import ehcd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Input word.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,   // [23:0] elapsed_hours
   // Result word.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // [4:0] local_day, [8:5] local_month,
                                               // [24:9] local_year, [34:25] local_hour,
                                               // [39:35] zero
   // Register writes.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [HOUR_W-1:0]       hours_per_day_ff;
   logic [DAY_W-1:0]        base_day_ff;
   logic [MONTH_W-1:0]      base_month_ff;
   logic [BASE_YEAR_W-1:0]  base_year_ff;
   logic [HOUR_W-1:0]       divisor;

   logic                    front_valid;
   logic                    front_ready;
   queue_item_type          front_item;
   logic                    queue_valid;
   logic                    queue_ready;
   queue_item_type          queue_item;

   logic [DAY_W-1:0]        local_day;
   logic [MONTH_W-1:0]      local_month;
   logic [YEAR_W-1:0]       local_year;
   logic [HOUR_W-1:0]       local_hour;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hours_per_day_ff <= 10'd24;
         base_day_ff      <= 5'd1;
         base_month_ff    <= 4'd1;
         base_year_ff     <= 14'd2000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_HOURS_PER_DAY: hours_per_day_ff <= csr_data[HOUR_W-1:0];
            REG_BASE_DAY:      base_day_ff      <= csr_data[DAY_W-1:0];
            REG_BASE_MONTH:    base_month_ff    <= csr_data[MONTH_W-1:0];
            REG_BASE_YEAR:     base_year_ff     <= csr_data[BASE_YEAR_W-1:0];
            default:           base_year_ff     <= base_year_ff;
         endcase
      end
   end

   // A zero day length divides as one.
   assign divisor = (hours_per_day_ff == '0) ? HOUR_W'(1) : hours_per_day_ff;

   ehcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_hours  (req_tdata[HOURS_W-1:0]),
      .divisor   (divisor),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   ehcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   ehcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_item    (queue_item),
      .base_day   (base_day_ff),
      .base_month (base_month_ff),
      .base_year  (base_year_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_day    (local_day),
      .out_month  (local_month),
      .out_year   (local_year),
      .out_hour   (local_hour)
   );

   // Pack the result word, first field in the lowest bits.
   assign rsp_tdata = {5'd0, local_hour, local_year, local_month, local_day};

endmodule

// File: design/ehcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elapsed hours to calendar date: front
// Accepts an hour count and splits it into whole days and the hour of the
// day with a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ehcd_front
   import ehcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [HOURS_W-1:0]   in_hours,
   input  logic [HOUR_W-1:0]    divisor,
   output logic                 out_valid,
   input  logic                 out_ready,
   output queue_item_type       out_item
);

   localparam int CNT_W = $clog2(DAYS_W);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DAYS_W - 1);

   front_state_type        state_ff, state_in;
   logic [DAYS_W-1:0]      quot_ff, quot_in;
   logic [HOUR_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [HOUR_W:0]        partial;
   logic [HOUR_W:0]        diff;
   logic                   fits;

   // One restoring division step.
   always_comb begin
      partial = {rem_ff, quot_ff[DAYS_W-1]};
      diff    = partial - {1'b0, divisor};
      fits    = partial >= {1'b0, divisor};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE:   if (in_valid) state_in = FRONT_DIVIDE;
         FRONT_DIVIDE: if (count_ff == LAST_BIT) state_in = FRONT_PUSH;
         FRONT_PUSH:   if (out_ready) state_in = FRONT_IDLE;
         default:      state_in = FRONT_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         FRONT_IDLE: in_ready  = 1'b1;
         FRONT_PUSH: out_valid = 1'b1;
         default: begin
            in_ready  = 1'b0;
            out_valid = 1'b0;
         end
      endcase
   end

   // Divider datapath.
   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      if (state_ff == FRONT_IDLE && in_valid) begin
         quot_in  = in_hours;
         rem_in   = '0;
         count_in = '0;
      end else if (state_ff == FRONT_DIVIDE) begin
         quot_in  = {quot_ff[DAYS_W-2:0], fits};
         rem_in   = fits ? diff[HOUR_W-1:0] : partial[HOUR_W-1:0];
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
   end

   assign out_item.days = quot_ff;
   assign out_item.hour = rem_ff;

endmodule

// File: design/ehcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elapsed hours to calendar date: queue
// Small first-in first-out buffer of day counts and hours between the
// divider and the date stepper.
// ----------------------------------------------------------------------------
module ehcd_queue
   import ehcd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  queue_item_type  in_item,
   output logic            out_valid,
   input  logic            out_ready,
   output queue_item_type  out_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   queue_item_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: design/ehcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elapsed hours to calendar date: back
// Adds a day count to the base date one step per cycle: a 400-year cycle, a
// whole year from the first of January, or one month, then the final days.
// Holds the finished date until the result word is taken.
// ----------------------------------------------------------------------------
module ehcd_back
   import ehcd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  queue_item_type          in_item,
   input  logic [DAY_W-1:0]        base_day,
   input  logic [MONTH_W-1:0]      base_month,
   input  logic [BASE_YEAR_W-1:0]  base_year,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [DAY_W-1:0]        out_day,
   output logic [MONTH_W-1:0]      out_month,
   output logic [YEAR_W-1:0]       out_year,
   output logic [HOUR_W-1:0]       out_hour
);

   localparam int SUM_W = DAYS_ACC_W + 1;
   localparam logic [YMOD_W-1:0]  YMOD_LAST = 9'd399;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

   back_state_type          state_ff, state_in;
   logic [DAYS_ACC_W-1:0]   days_ff, days_in;
   logic [DAY_W-1:0]        day_ff, day_in;
   logic [MONTH_W-1:0]      month_ff, month_in;
   logic [YEAR_W-1:0]       year_ff, year_in;
   logic [YMOD_W-1:0]       ymod_ff, ymod_in;
   logic [HOUR_W-1:0]       hour_ff, hour_in;

   logic                    leap;
   logic [DAY_W-1:0]        dim;
   logic [8:0]              ylen;
   logic [SUM_W-1:0]        day_sum;
   logic [SUM_W-1:0]        month_rest;
   logic [YMOD_W-1:0]       ymod_next;
   logic [MONTH_W-1:0]      start_month;

   // Calendar facts of the current month.
   always_comb begin
      leap       = leap_year(ymod_ff);
      dim        = month_days(month_ff, leap);
      ylen       = year_length(leap);
      day_sum    = SUM_W'(days_ff) + SUM_W'(day_ff);
      month_rest = day_sum - SUM_W'(dim) - SUM_W'(1);
      ymod_next  = (ymod_ff == YMOD_LAST) ? '0 : ymod_ff + 1'b1;
   end

   // A base month of zero counts as January, any month past December as December.
   always_comb begin
      if (base_month == '0) begin
         start_month = MONTH_JAN;
      end else if (base_month > MONTH_DEC) begin
         start_month = MONTH_DEC;
      end else begin
         start_month = base_month;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: if (in_valid) state_in = BACK_RUN;
         BACK_RUN:  if (days_ff == '0) state_in = BACK_DONE;
         BACK_DONE: if (out_ready) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         BACK_IDLE: in_ready  = 1'b1;
         BACK_DONE: out_valid = 1'b1;
         default: begin
            in_ready  = 1'b0;
            out_valid = 1'b0;
         end
      endcase
   end

   // Date stepper.
   always_comb begin
      days_in  = days_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      ymod_in  = ymod_ff;
      hour_in  = hour_ff;
      if (state_ff == BACK_IDLE && in_valid) begin
         days_in  = DAYS_ACC_W'(in_item.days);
         hour_in  = in_item.hour;
         day_in   = base_day;
         month_in = start_month;
         year_in  = YEAR_W'(base_year);
         ymod_in  = year_mod_400(base_year);
      end else if (state_ff == BACK_RUN && days_ff != '0) begin
         if (day_ff == DAY_FIRST && days_ff >= DAYS_PER_400_YEARS) begin
            // The calendar repeats every 400 years from any first of a month.
            days_in = days_ff - DAYS_PER_400_YEARS;
            year_in = year_ff + YEAR_W'(400);
         end else if (day_ff == DAY_FIRST && month_ff == MONTH_JAN &&
                      days_ff >= DAYS_ACC_W'(ylen)) begin
            // A whole year from the first of January.
            days_in = days_ff - DAYS_ACC_W'(ylen);
            year_in = year_ff + 1'b1;
            ymod_in = ymod_next;
         end else if (day_sum <= SUM_W'(dim)) begin
            // The remaining days end inside this month.
            day_in  = day_sum[DAY_W-1:0];
            days_in = '0;
         end else begin
            // Move to the first of the next month.
            days_in = month_rest[DAYS_ACC_W-1:0];
            day_in  = DAY_FIRST;
            if (month_ff >= MONTH_DEC) begin
               month_in = MONTH_JAN;
               year_in  = year_ff + 1'b1;
               ymod_in  = ymod_next;
            end else begin
               month_in = month_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      days_ff  <= days_in;
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      ymod_ff  <= ymod_in;
      hour_ff  <= hour_in;
   end

   assign out_day   = day_ff;
   assign out_month = month_ff;
   assign out_year  = year_ff;
   assign out_hour  = hour_ff;

endmodule

// File: bench/tb_elapsed_hours_to_calendar_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elapsed hours to calendar date: self-checking testbench
// Drives hour counts into the converter under many calendar settings and
// compares every result word, field by field, with a table value or a date
// predictor kept in the bench. A short table of corner cases comes first, then
// random phases with bursty input, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_elapsed_hours_to_calendar_date
   import ehcd_pkg::*;
();

   localparam int RSP_W           = 40;
   localparam int DATE_W          = 35;
   localparam int DAYS_PER_CYCLE  = 146097;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int END_CYCLES      = 200;
   localparam int RANDOM_PHASES   = 10;
   localparam int WORDS_PER_PHASE = 40;

   // Result fields; the first declared member sits in the highest bits.
   typedef struct packed {
      logic [HOUR_W-1:0]  hour;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } local_date_type;

   typedef logic [3:0][CSR_DATA_W-1:0] calendar_regs_type;

   typedef struct {
      calendar_regs_type  regs;
      logic [HOURS_W-1:0] hours;
      bit                 literal;
      local_date_type     want;
   } corner_row_type;

   typedef enum int {
      SINK_OPEN,
      SINK_RANDOM,
      SINK_PERIODIC,
      SINK_SPARSE
   } sink_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [HOURS_W-1:0]    req_tdata = '0;     // [23:0] elapsed_hours
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;          // [4:0] day, [8:5] month, [24:9] year,
                                              // [34:25] hour, [39:35] zero
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = REG_HOURS_PER_DAY;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Bench copy of the calendar registers, reset values included.
   logic [HOUR_W-1:0]      cfg_hours_per_day = 10'd24;
   logic [DAY_W-1:0]       cfg_base_day      = 5'd1;
   logic [MONTH_W-1:0]     cfg_base_month    = 4'd1;
   logic [BASE_YEAR_W-1:0] cfg_base_year     = 14'd2000;
   calendar_regs_type      applied_regs;

   local_date_type pending_dates[$];
   corner_row_type corner_rows[$];

   int  words_sent       = 0;
   int  results_checked  = 0;
   int  settings_applied = 0;
   int  mismatches       = 0;
   int  hold_offs_done   = 0;
   int  idle_cycles      = 0;
   int  burst_left       = 0;
   bit  gaps_enabled     = 1'b1;
   bit  hold_off_pending = 1'b0;

   elapsed_hours_to_calendar_date dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Free-running clock.
   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int days_in_month(input int month, input int year);
      bit leap;
      leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      case (month)
         2:            return leap ? 29 : 28;
         4, 6, 9, 11:  return 30;
         default:      return 31;
      endcase
   endfunction

   // Divide by the day length, then walk the quotient forward from the base
   // date one month at a time, skipping whole 400-year cycles from a first.
   function automatic local_date_type predict_local_date(input logic [HOURS_W-1:0] hours);
      int divisor, days_left, day, month, year, month_len;
      local_date_type date;
      divisor   = (cfg_hours_per_day == 0) ? 1 : int'(cfg_hours_per_day);
      days_left = int'(hours) / divisor;
      day       = int'(cfg_base_day);
      month     = int'(cfg_base_month);
      year      = int'(cfg_base_year);
      if (month == 0) month = 1;
      if (month > 12) month = 12;
      while (days_left > 0) begin
         month_len = days_in_month(month, year);
         if (day == 1 && days_left >= DAYS_PER_CYCLE) begin
            days_left -= DAYS_PER_CYCLE;
            year += 400;
         end else if (day + days_left <= month_len) begin
            day += days_left;
            days_left = 0;
         end else begin
            // A day past the end of its month can make this step add days.
            days_left -= month_len - day + 1;
            day = 1;
            month++;
            if (month > 12) begin
               month = 1;
               year++;
            end
         end
      end
      date.day   = DAY_W'(day);
      date.month = MONTH_W'(month);
      date.year  = YEAR_W'(year);
      date.hour  = HOUR_W'(int'(hours) % divisor);
      return date;
   endfunction

   function automatic void add_row(input int hpd, input int day, input int month,
                                   input int year, input int hours, input bit literal,
                                   input int want_day = 0, input int want_month = 0,
                                   input int want_year = 0, input int want_hour = 0);
      corner_row_type row;
      row.regs[REG_HOURS_PER_DAY] = CSR_DATA_W'(hpd);
      row.regs[REG_BASE_DAY]      = CSR_DATA_W'(day);
      row.regs[REG_BASE_MONTH]    = CSR_DATA_W'(month);
      row.regs[REG_BASE_YEAR]     = CSR_DATA_W'(year);
      row.hours      = HOURS_W'(hours);
      row.literal    = literal;
      row.want.day   = DAY_W'(want_day);
      row.want.month = MONTH_W'(want_month);
      row.want.year  = YEAR_W'(want_year);
      row.want.hour  = HOUR_W'(want_hour);
      corner_rows.push_back(row);
   endfunction

   function automatic void report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare one result word with the oldest outstanding date.
   task automatic check_result(input logic [RSP_W-1:0] word);
      local_date_type want, got;
      got = word[DATE_W-1:0];
      if (pending_dates.size() == 0) begin
         $display("%0t ns: result word expected none actual %h", $time, word);
         mismatches++;
      end else begin
         want = pending_dates.pop_front();
         report_field("local_day", int'(want.day), int'(got.day));
         report_field("local_month", int'(want.month), int'(got.month));
         report_field("local_year", int'(want.year), int'(got.year));
         report_field("local_hour", int'(want.hour), int'(got.hour));
         report_field("pad bits", 0, int'(word[RSP_W-1:DATE_W]));
         results_checked++;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_hours(input logic [HOURS_W-1:0] hours, input bit literal,
                             input local_date_type want);
      req_tvalid <= 1'b1;
      req_tdata  <= hours;
      do @(posedge clock); while (!req_tready);
      pending_dates.push_back(literal ? want : predict_local_date(hours));
      words_sent++;
      @(negedge clock);
   endtask

   // Bursts of random length separated by random gaps when gaps are enabled.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if (gaps_enabled) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   endtask

   // Every word yields a result, so an empty queue means the block is idle.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all four registers back to back, keeping valid high between them.
   task automatic write_calendar_regs(input calendar_regs_type values);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= values[i];
         do @(posedge clock); while (!csr_ready);
         case (csr_index_type'(i))
            REG_HOURS_PER_DAY: cfg_hours_per_day = values[i][HOUR_W-1:0];
            REG_BASE_DAY:      cfg_base_day      = values[i][DAY_W-1:0];
            REG_BASE_MONTH:    cfg_base_month    = values[i][MONTH_W-1:0];
            default:           cfg_base_year     = values[i][BASE_YEAR_W-1:0];
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      applied_regs = values;
      settings_applied++;
   endtask

   function automatic calendar_regs_type random_calendar_regs();
      calendar_regs_type regs;
      case ($urandom_range(0, 5))
         0:       regs[REG_HOURS_PER_DAY] = '0;
         1:       regs[REG_HOURS_PER_DAY] = CSR_DATA_W'(1);
         2:       regs[REG_HOURS_PER_DAY] = CSR_DATA_W'(1023);
         3:       regs[REG_HOURS_PER_DAY] = CSR_DATA_W'(24);
         default: regs[REG_HOURS_PER_DAY] = CSR_DATA_W'($urandom_range(0, 16383));
      endcase
      regs[REG_BASE_DAY] = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom_range(0, 31))
                                                       : CSR_DATA_W'($urandom_range(1, 28));
      regs[REG_BASE_MONTH] = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom_range(0, 15))
                                                         : CSR_DATA_W'($urandom_range(1, 12));
      case ($urandom_range(0, 5))
         0:       regs[REG_BASE_YEAR] = CSR_DATA_W'(1);
         1:       regs[REG_BASE_YEAR] = CSR_DATA_W'(16383);
         2:       regs[REG_BASE_YEAR] = CSR_DATA_W'(1900);
         3:       regs[REG_BASE_YEAR] = CSR_DATA_W'($urandom_range(1, 16383));
         default: regs[REG_BASE_YEAR] = CSR_DATA_W'($urandom_range(1600, 2400));
      endcase
      return regs;
   endfunction

   // Mix of full-range counts, short spans, day boundaries and scaled values.
   function automatic logic [HOURS_W-1:0] random_hours();
      int divisor;
      divisor = (cfg_hours_per_day == 0) ? 1 : int'(cfg_hours_per_day);
      case ($urandom_range(0, 3))
         0:       return HOURS_W'($urandom);
         1:       return HOURS_W'($urandom_range(0, 9600));
         2:       return HOURS_W'(divisor * $urandom_range(0, 3000) + $urandom_range(0, 2) - 1);
         default: return HOURS_W'($urandom >> $urandom_range(8, 31));
      endcase
   endfunction

   // Result sink: ready follows a changing pattern, with one long hold-off
   // on request while the sender keeps offering words.
   initial begin : result_sink
      sink_mode_type mode;
      int mode_left, tick;
      bit ready_next;
      mode = SINK_OPEN;
      mode_left = 0;
      tick = 0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_pending = 1'b0;
            hold_offs_done++;
         end else begin
            if (mode_left == 0) begin
               mode = sink_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            tick++;
            case (mode)
               SINK_OPEN:     ready_next = 1'b1;
               SINK_RANDOM:   ready_next = 1'($urandom_range(0, 1));
               SINK_PERIODIC: ready_next = (tick % 4) != 3;
               default:       ready_next = ($urandom_range(0, 3) == 0);
            endcase
            rsp_tready <= ready_next;
            @(negedge clock);
         end
      end
   end

   // Result checking and the no-progress watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_tvalid && rsp_tready)
            check_result(rsp_tdata);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_dates.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Stimulus: corner table, then random phases, then drain and verdict.
   initial begin : stimulus
      corner_row_type    row;
      calendar_regs_type regs;
      applied_regs[REG_HOURS_PER_DAY] = CSR_DATA_W'(24);
      applied_regs[REG_BASE_DAY]      = CSR_DATA_W'(1);
      applied_regs[REG_BASE_MONTH]    = CSR_DATA_W'(1);
      applied_regs[REG_BASE_YEAR]     = CSR_DATA_W'(2000);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings and the largest count.
      add_row(24, 1, 1, 2000, 0, 1, 1, 1, 2000, 0);
      add_row(24, 1, 1, 2000, 23, 1, 1, 1, 2000, 23);
      add_row(24, 1, 1, 2000, 24, 1, 2, 1, 2000, 0);
      add_row(24, 1, 1, 2000, 24'hFFFFFF, 0);
      // A zero day length counts every hour as a day; then the largest day length.
      add_row(0, 1, 1, 2000, 5, 1, 6, 1, 2000, 0);
      add_row(0, 1, 1, 2000, 24'hFFFFFF, 0);
      add_row(1023, 1, 1, 2000, 1022, 1, 1, 1, 2000, 1022);
      add_row(1023, 1, 1, 2000, 24'hFFFFFF, 0);
      // Bits above the register width are dropped, leaving a 24-hour day; then a one-hour day.
      add_row(14'h3C18, 1, 1, 2000, 47, 1, 2, 1, 2000, 23);
      add_row(1, 1, 1, 1, 0, 1, 1, 1, 1, 0);
      add_row(1, 31, 12, 16383, 24'hFFFFFF, 0);
      // Base month below and above the calendar range.
      add_row(24, 15, 0, 2001, 0, 1, 15, 1, 2001, 0);
      add_row(24, 15, 13, 2001, 0, 1, 15, 12, 2001, 0);
      add_row(24, 15, 15, 2001, 480, 0);
      // Day zero and a day past the end of February.
      add_row(24, 0, 3, 2001, 0, 1, 0, 3, 2001, 0);
      add_row(24, 0, 3, 2001, 24, 0);
      add_row(24, 31, 2, 2001, 0, 1, 31, 2, 2001, 0);
      add_row(24, 31, 2, 2001, 48, 0);
      // Leap-year rules.
      add_row(24, 28, 2, 2000, 24, 1, 29, 2, 2000, 0);
      add_row(24, 28, 2, 1900, 24, 1, 1, 3, 1900, 0);
      add_row(24, 28, 2, 2400, 24, 1, 29, 2, 2400, 0);
      // Exactly one 400-year cycle, one day short of it, and a year roll.
      add_row(1, 1, 1, 2000, 146097, 1, 1, 1, 2400, 0);
      add_row(1, 1, 1, 2000, 146096, 1, 31, 12, 2399, 0);
      add_row(1, 31, 12, 1999, 1, 1, 1, 1, 2000, 0);

      foreach (corner_rows[i]) begin
         row = corner_rows[i];
         if (row.regs != applied_regs) begin
            wait_for_idle();
            write_calendar_regs(row.regs);
         end
         send_hours(row.hours, row.literal, row.want);
         pace_sender();
      end

      // Random phases; the first two use the register extremes.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_idle();
         if (phase == 0) begin
            regs[REG_HOURS_PER_DAY] = CSR_DATA_W'(1023);
            regs[REG_BASE_DAY]      = CSR_DATA_W'(31);
            regs[REG_BASE_MONTH]    = CSR_DATA_W'(12);
            regs[REG_BASE_YEAR]     = CSR_DATA_W'(16383);
         end else if (phase == 1) begin
            regs[REG_HOURS_PER_DAY] = CSR_DATA_W'(1);
            regs[REG_BASE_DAY]      = CSR_DATA_W'(1);
            regs[REG_BASE_MONTH]    = CSR_DATA_W'(1);
            regs[REG_BASE_YEAR]     = CSR_DATA_W'(1);
         end else begin
            regs = random_calendar_regs();
         end
         write_calendar_regs(regs);
         gaps_enabled = (phase % 3) != 2;
         // Stall the receiver for a long stretch while words keep coming.
         if (phase == 3) begin
            gaps_enabled = 1'b0;
            hold_off_pending = 1'b1;
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_hours(random_hours(), 1'b0, '0);
            pace_sender();
            if ($urandom_range(0, 59) == 0)
               wait_for_idle();
         end
      end

      wait_for_idle();
      repeat (END_CYCLES) @(negedge clock);

      $display("Run covered %0d input words and %0d checked results over %0d register settings.",
               words_sent, results_checked, settings_applied);
      $display("Receiver hold-offs: %0d; field mismatches: %0d.", hold_offs_done, mismatches);
      if (mismatches == 0 && pending_dates.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
design/ehcd_pkg.sv
design/ehcd_front.sv
design/ehcd_queue.sv
design/ehcd_back.sv
design/elapsed_hours_to_calendar_date.sv
bench/tb_elapsed_hours_to_calendar_date.sv
